@@ rtl/tqr_pkg.sv @@
// ----------------------------------------------------------------------------
// tqr_pkg: shared types and constants of the trackball rotation unit
// Register indexes, default widths and the sign table of the quaternion
// product.
// ----------------------------------------------------------------------------
package tqr_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int REG_BITS       = 13;
  localparam int IDX_BITS       = 1;

  localparam logic [IDX_BITS-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [IDX_BITS-1:0] REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [REG_BITS-1:0] DIM_RESET = 13'd720;

  // control word of the shared multiply-accumulate unit
  typedef struct packed {
    logic clr;
    logic issue;
    logic neg;
  } mac_ctl_t;

  // term k of component c of r*o uses o[c^k]; this gives its sign
  function automatic logic pq_neg(input logic [1:0] c, input logic [1:0] k);
    logic n;
    case (c)
      2'd0:    n = (k != 2'd0);
      2'd1:    n = (k == 2'd3);
      2'd2:    n = (k == 2'd1);
      default: n = (k == 2'd2);
    endcase
    return n;
  endfunction

endpackage

@@ rtl/tqr_mac.sv @@
// ----------------------------------------------------------------------------
// tqr_mac: shared multiply-accumulate unit
// One signed multiply per cycle into a product register, summed into the
// accumulator on the following cycle.
// ----------------------------------------------------------------------------
module tqr_mac #(
  parameter int FRAC_BITS = tqr_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tqr_pkg::mac_ctl_t            ctl,
  input  logic signed [FRAC_BITS+3:0]  a,
  input  logic signed [FRAC_BITS+3:0]  b,
  input  logic signed [2*FRAC_BITS+9:0] init,
  output logic signed [2*FRAC_BITS+9:0] acc
);

  localparam int DW = FRAC_BITS + 4;
  localparam int AW = 2 * FRAC_BITS + 10;

  logic signed [2*DW-1:0] prod;
  logic                   p_vld;
  logic                   p_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= ctl.issue;
    end
    prod  <= a * b;
    p_neg <= ctl.neg;
    if (ctl.clr) begin
      acc <= init;
    end else if (p_vld) begin
      acc <= p_neg ? acc - AW'(prod) : acc + AW'(prod);
    end
  end

endmodule

@@ rtl/tqr_div.sv @@
// ----------------------------------------------------------------------------
// tqr_div: bit-serial rounding divider
// Divides a sign and magnitude by a positive divisor, one quotient bit per
// cycle, rounding to nearest with ties away from zero.
// ----------------------------------------------------------------------------
module tqr_div #(
  parameter int FRAC_BITS = tqr_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        neg,
  input  logic [2*FRAC_BITS+2:0]      mag,
  input  logic [FRAC_BITS+2:0]        den,
  output logic                        done,
  output logic signed [FRAC_BITS+3:0] quot
);

  localparam int NW  = 2 * FRAC_BITS + 3;
  localparam int NI  = NW + 1;
  localparam int DVW = FRAC_BITS + 3;
  localparam int DW  = FRAC_BITS + 4;
  localparam int CW  = $clog2(NI + 1);

  logic [NI-1:0]  dq;
  logic [DVW-1:0] dv;
  logic [DVW-1:0] rem;
  logic [DVW:0]   rem_sh;
  logic [DVW:0]   rem_sub;
  logic           fits;
  logic           sg;
  logic [CW-1:0]  cnt;
  logic           run;

  assign rem_sh  = {rem, dq[NI-1]};
  assign fits    = rem_sh >= {1'b0, dv};
  assign rem_sub = rem_sh - {1'b0, dv};
  assign quot    = sg ? -DW'(dq) : DW'(dq);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // add half the divisor first so the floor quotient rounds
        dq  <= NI'(mag) + NI'(den >> 1);
        dv  <= den;
        rem <= '0;
        sg  <= neg;
        cnt <= CW'(NI);
        run <= 1'b1;
      end else if (run) begin
        rem <= fits ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
        dq  <= {dq[NI-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/tqr_sqrt.sv @@
// ----------------------------------------------------------------------------
// tqr_sqrt: bit-serial integer square root
// Floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module tqr_sqrt #(
  parameter int FRAC_BITS = tqr_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [2*FRAC_BITS+5:0]  rad_in,
  output logic                    done,
  output logic [FRAC_BITS+2:0]    root
);

  localparam int SW = 2 * FRAC_BITS + 6;
  localparam int HS = SW / 2;
  localparam int RW = FRAC_BITS + 6;
  localparam int CW = $clog2(HS + 1);

  logic [SW-1:0] rad;
  logic [RW-1:0] rem;
  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;
  logic          fits;
  logic [CW-1:0] cnt;
  logic          run;

  assign rem_sh = {rem[RW-3:0], rad[SW-1:SW-2]};
  assign trial  = RW'({root, 2'b01});
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= rad_in;
        rem  <= '0;
        root <= '0;
        cnt  <= CW'(HS);
        run  <= 1'b1;
      end else if (run) begin
        rem  <= fits ? rem_sh - trial : rem_sh;
        root <= {root[HS-2:0], fits};
        rad  <= rad << 2;
        cnt  <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/trackball_quaternion_rotation_unit.sv @@
// Press word: result in the cycle after acceptance. Move word: the result waits
// on the bit-serial divider (up to 16 divisions) and the square-root unit.
// One word at a time; the input stalls from acceptance until the result is taken.
// Reset: window 720x720, stored position zero, orientation identity.
// ----------------------------------------------------------------------------
// trackball_quaternion_rotation_unit: virtual trackball in fixed point
// A sequencer drives one multiply-accumulate, one divider and one square-root
// unit through the sphere lift, rotation quaternion and orientation update.
// ----------------------------------------------------------------------------
module trackball_quaternion_rotation_unit #(
  parameter int COORD_BITS = tqr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tqr_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tqr_pkg::IDX_BITS-1:0]        cfg_index,
  input  logic [tqr_pkg::REG_BITS-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                req_type,
  input  logic [COORD_BITS-1:0]               pointer_x,
  input  logic [COORD_BITS-1:0]               pointer_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [FRAC_BITS+1:0]         rot_w,
  output logic signed [FRAC_BITS+1:0]         rot_x,
  output logic signed [FRAC_BITS+1:0]         rot_y,
  output logic signed [FRAC_BITS+1:0]         rot_z,
  output logic                                degenerate
);

  localparam int RB  = tqr_pkg::REG_BITS;
  localparam int DW  = FRAC_BITS + 4;
  localparam int AW  = 2 * FRAC_BITS + 10;
  localparam int NW  = 2 * FRAC_BITS + 3;
  localparam int DVW = FRAC_BITS + 3;
  localparam int SW  = 2 * FRAC_BITS + 6;
  localparam int RTW = FRAC_BITS + 3;
  localparam int OW  = FRAC_BITS + 2;
  localparam int PW  = (COORD_BITS > RB) ? COORD_BITS : RB;

  localparam logic signed [AW-1:0] ONE2  = AW'(1) << (2 * FRAC_BITS);
  localparam logic [AW-1:0]        HALF  = AW'(1) << (FRAC_BITS - 1);
  localparam logic signed [DW-1:0] ONE_D = DW'(1) << FRAC_BITS;
  localparam logic signed [OW-1:0] ONE_O = OW'(1) << FRAC_BITS;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_LX   = 14'b00000000000010,
    S_LY   = 14'b00000000000100,
    S_LD   = 14'b00000000001000,
    S_LSQ  = 14'b00000000010000,
    S_LDX  = 14'b00000000100000,
    S_LDY  = 14'b00000001000000,
    S_RMAC = 14'b00000010000000,
    S_NMAC = 14'b00000100000000,
    S_NSQ  = 14'b00001000000000,
    S_NDIV = 14'b00010000000000,
    S_PMAC = 14'b00100000000000,
    S_ORI  = 14'b01000000000000,
    S_OUT  = 14'b10000000000000
  } state_t;

  state_t state;

  logic [RB-1:0]         cfg_w, cfg_h, w_q, h_q;
  logic [COORD_BITS-1:0] last_px, last_py;
  logic [RB-1:0]         opx, opy, cpx, cpy;
  logic                  pt, big, nf, launched, degen_r;
  logic [1:0]            ci;
  logic [2:0]            kcnt;
  logic signed [DW-1:0]  x_r, y_r;
  logic [RTW-1:0]        nn;
  logic signed [DW-1:0]  uu [3];
  logic signed [DW-1:0]  vv [3];
  logic signed [DW-1:0]  q  [4];
  logic signed [DW-1:0]  p  [3];
  logic signed [OW-1:0]  o  [4];

  // window size and clamped positions
  logic [RB-1:0] w_eff, h_eff;
  logic [PW-1:0] nx_pw, ny_pw, ox_pw, oy_pw;

  assign w_eff = (cfg_w == '0) ? RB'(1) : cfg_w;
  assign h_eff = (cfg_h == '0) ? RB'(1) : cfg_h;
  assign nx_pw = (PW'(pointer_x) > PW'(w_eff)) ? PW'(w_eff) : PW'(pointer_x);
  assign ny_pw = (PW'(pointer_y) > PW'(h_eff)) ? PW'(h_eff) : PW'(pointer_y);
  assign ox_pw = (PW'(last_px) > PW'(w_eff)) ? PW'(w_eff) : PW'(last_px);
  assign oy_pw = (PW'(last_py) > PW'(h_eff)) ? PW'(h_eff) : PW'(last_py);

  // lift numerators (2px - w) and (h - 2py) as sign and magnitude
  logic [RB:0] sx2, sy2, wq1, hq1, lx_mag, ly_mag;
  logic        lx_neg, ly_neg;

  assign sx2    = {pt ? cpx : opx, 1'b0};
  assign sy2    = {pt ? cpy : opy, 1'b0};
  assign wq1    = {1'b0, w_q};
  assign hq1    = {1'b0, h_q};
  assign lx_neg = sx2 < wq1;
  assign ly_neg = sy2 > hq1;
  assign lx_mag = lx_neg ? wq1 - sx2 : sx2 - wq1;
  assign ly_mag = ly_neg ? sy2 - hq1 : hq1 - sy2;

  function automatic logic [DW-1:0] abs_d(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  function automatic logic signed [DW-1:0] rnd_q(input logic signed [AW-1:0] v);
    logic [AW-1:0] m;
    logic [AW-1:0] r;
    m = v[AW-1] ? AW'(-v) : AW'(v);
    r = (m + HALF) >> FRAC_BITS;
    return v[AW-1] ? -DW'(r) : DW'(r);
  endfunction

  function automatic logic signed [OW-1:0] clamp_o(input logic signed [DW-1:0] v);
    logic signed [OW-1:0] c;
    if (v > ONE_D) begin
      c = ONE_O;
    end else if (v < -ONE_D) begin
      c = -ONE_O;
    end else begin
      c = v[OW-1:0];
    end
    return c;
  endfunction

  // shared multiply-accumulate
  tqr_pkg::mac_ctl_t    mac_ctl;
  logic signed [DW-1:0] mac_a, mac_b;
  logic signed [AW-1:0] mac_init, acc;
  logic [2:0]           mac_n;
  logic                 mac_st, mac_fin;
  logic [1:0]           kk;

  assign kk      = kcnt[1:0];
  assign mac_st  = (state == S_LD) || (state == S_RMAC) || (state == S_NMAC) ||
                   (state == S_PMAC);
  assign mac_fin = mac_st && (kcnt == mac_n + 3'd1);

  always_comb begin
    mac_a    = q[kk];
    mac_b    = q[kk];
    mac_ctl.neg = 1'b0;
    mac_n    = 3'd4;
    mac_init = '0;
    case (state)
      S_LD: begin
        mac_a = kcnt[0] ? y_r : x_r;
        mac_b = kcnt[0] ? y_r : x_r;
        mac_n = 3'd2;
      end
      S_RMAC: begin
        case (ci)
          2'd0: begin
            mac_n    = 3'd3;
            mac_init = ONE2;
            case (kk)
              2'd0:    begin mac_a = uu[0]; mac_b = vv[0]; end
              2'd1:    begin mac_a = uu[1]; mac_b = vv[1]; end
              default: begin mac_a = uu[2]; mac_b = vv[2]; end
            endcase
          end
          2'd1: begin
            mac_n = 3'd2;
            mac_ctl.neg = (kk != 2'd0);
            mac_a = (kk == 2'd0) ? uu[1] : uu[2];
            mac_b = (kk == 2'd0) ? vv[2] : vv[1];
          end
          2'd2: begin
            mac_n = 3'd2;
            mac_ctl.neg = (kk != 2'd0);
            mac_a = (kk == 2'd0) ? uu[2] : uu[0];
            mac_b = (kk == 2'd0) ? vv[0] : vv[2];
          end
          default: begin
            mac_n = 3'd2;
            mac_ctl.neg = (kk != 2'd0);
            mac_a = (kk == 2'd0) ? uu[0] : uu[1];
            mac_b = (kk == 2'd0) ? vv[1] : vv[0];
          end
        endcase
      end
      S_PMAC: begin
        mac_a = q[kk];
        mac_b = DW'(o[ci ^ kk]);
        mac_ctl.neg = tqr_pkg::pq_neg(ci, kk);
      end
      default: ;
    endcase
    mac_ctl.clr   = mac_st && (kcnt == 3'd0);
    mac_ctl.issue = mac_st && (kcnt < mac_n);
  end

  tqr_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .a    (mac_a),
    .b    (mac_b),
    .init (mac_init),
    .acc  (acc)
  );

  // shared divider
  logic                 div_st, div_start, div_done, div_neg;
  logic [NW-1:0]        div_mag;
  logic [DVW-1:0]       div_den;
  logic signed [DW-1:0] quot;

  assign div_st    = (state == S_LX) || (state == S_LY) || (state == S_LDX) ||
                     (state == S_LDY) || (state == S_NDIV);
  assign div_start = div_st && !launched;

  always_comb begin
    div_neg = 1'b0;
    div_mag = '0;
    div_den = DVW'(1);
    case (state)
      S_LX: begin
        div_neg = lx_neg;
        div_mag = NW'(lx_mag) << FRAC_BITS;
        div_den = DVW'(w_q);
      end
      S_LY: begin
        div_neg = ly_neg;
        div_mag = NW'(ly_mag) << FRAC_BITS;
        div_den = DVW'(h_q);
      end
      S_LDX: begin
        div_neg = x_r[DW-1];
        div_mag = NW'(abs_d(x_r)) << FRAC_BITS;
        div_den = nn;
      end
      S_LDY: begin
        div_neg = y_r[DW-1];
        div_mag = NW'(abs_d(y_r)) << FRAC_BITS;
        div_den = nn;
      end
      S_NDIV: begin
        div_neg = q[ci][DW-1];
        div_mag = NW'(abs_d(q[ci])) << FRAC_BITS;
        div_den = nn;
      end
      default: ;
    endcase
  end

  tqr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .neg   (div_neg),
    .mag   (div_mag),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  // shared square root
  logic             sq_start, sq_done;
  logic [SW-1:0]    sq_rad;
  logic [RTW-1:0]   root;
  logic signed [AW-1:0] one2_d;

  assign one2_d   = ONE2 - acc;
  assign sq_start = ((state == S_LSQ) || (state == S_NSQ)) && !launched;
  assign sq_rad   = ((state == S_LSQ) && !big) ? one2_d[SW-1:0] : acc[SW-1:0];

  tqr_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .start  (sq_start),
    .rad_in (sq_rad),
    .done   (sq_done),
    .root   (root)
  );

  assign in_stall   = (state != S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign rot_w      = o[0];
  assign rot_x      = o[1];
  assign rot_y      = o[2];
  assign rot_z      = o[3];
  assign degenerate = degen_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cfg_w    <= tqr_pkg::DIM_RESET;
      cfg_h    <= tqr_pkg::DIM_RESET;
      last_px  <= '0;
      last_py  <= '0;
      o[0]     <= ONE_O;
      o[1]     <= '0;
      o[2]     <= '0;
      o[3]     <= '0;
      launched <= 1'b0;
      kcnt     <= '0;
      ci       <= '0;
      pt       <= 1'b0;
      nf       <= 1'b0;
      big      <= 1'b0;
      degen_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tqr_pkg::REG_SCREEN_WIDTH:  cfg_w <= cfg_data;
          tqr_pkg::REG_SCREEN_HEIGHT: cfg_h <= cfg_data;
          default: ;
        endcase
      end

      if (div_start || sq_start) begin
        launched <= 1'b1;
      end else if (div_done || sq_done) begin
        launched <= 1'b0;
      end

      if (mac_st) begin
        kcnt <= mac_fin ? 3'd0 : kcnt + 3'd1;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_px <= COORD_BITS'(nx_pw);
            last_py <= COORD_BITS'(ny_pw);
            degen_r <= 1'b0;
            w_q     <= w_eff;
            h_q     <= h_eff;
            cpx     <= nx_pw[RB-1:0];
            cpy     <= ny_pw[RB-1:0];
            opx     <= ox_pw[RB-1:0];
            opy     <= oy_pw[RB-1:0];
            pt      <= 1'b0;
            state   <= req_type ? S_LX : S_OUT;
          end
        end
        S_LX: begin
          if (div_done) begin
            x_r   <= quot;
            state <= S_LY;
          end
        end
        S_LY: begin
          if (div_done) begin
            y_r   <= quot;
            state <= S_LD;
          end
        end
        S_LD: begin
          if (mac_fin) begin
            big   <= acc > ONE2;
            state <= S_LSQ;
          end
        end
        S_LSQ: begin
          if (sq_done) begin
            if (big) begin
              nn    <= root;
              state <= S_LDX;
            end else begin
              if (pt) begin
                vv[0] <= x_r; vv[1] <= y_r; vv[2] <= DW'(root);
              end else begin
                uu[0] <= x_r; uu[1] <= y_r; uu[2] <= DW'(root);
              end
              pt    <= 1'b1;
              ci    <= 2'd0;
              state <= pt ? S_RMAC : S_LX;
            end
          end
        end
        S_LDX: begin
          if (div_done) begin
            if (pt) vv[0] <= quot; else uu[0] <= quot;
            state <= S_LDY;
          end
        end
        S_LDY: begin
          if (div_done) begin
            if (pt) begin
              vv[1] <= quot; vv[2] <= '0;
            end else begin
              uu[1] <= quot; uu[2] <= '0;
            end
            pt    <= 1'b1;
            ci    <= 2'd0;
            state <= pt ? S_RMAC : S_LX;
          end
        end
        S_RMAC: begin
          if (mac_fin) begin
            q[ci] <= rnd_q(acc);
            ci    <= ci + 2'd1;
            if (ci == 2'd3) begin
              nf    <= 1'b0;
              state <= S_NMAC;
            end
          end
        end
        S_NMAC: begin
          if (mac_fin) begin
            if (acc == '0) begin
              // zero length: keep orientation
              degen_r <= !nf;
              state   <= S_OUT;
            end else begin
              state <= S_NSQ;
            end
          end
        end
        S_NSQ: begin
          if (sq_done) begin
            if (root == '0) begin
              degen_r <= !nf;
              state   <= S_OUT;
            end else begin
              nn    <= root;
              ci    <= 2'd0;
              state <= S_NDIV;
            end
          end
        end
        S_NDIV: begin
          if (div_done) begin
            q[ci] <= quot;
            ci    <= ci + 2'd1;
            if (ci == 2'd3) begin
              state <= nf ? S_ORI : S_PMAC;
            end
          end
        end
        S_PMAC: begin
          if (mac_fin) begin
            ci <= ci + 2'd1;
            if (ci == 2'd3) begin
              // r is no longer needed: move the product into q
              q[0]  <= p[0];
              q[1]  <= p[1];
              q[2]  <= p[2];
              q[3]  <= rnd_q(acc);
              nf    <= 1'b1;
              state <= S_NMAC;
            end else begin
              p[ci] <= rnd_q(acc);
            end
          end
        end
        S_ORI: begin
          o[0]  <= clamp_o(q[0]);
          o[1]  <= clamp_o(q[1]);
          o[2]  <= clamp_o(q[2]);
          o[3]  <= clamp_o(q[3]);
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block took a word while still busy");

  a_rot_range: assert property (@(posedge clk) disable iff (rst)
    rot_w <= ONE_O && rot_w >= -ONE_O && rot_x <= ONE_O && rot_x >= -ONE_O &&
    rot_y <= ONE_O && rot_y >= -ONE_O && rot_z <= ONE_O && rot_z >= -ONE_O)
    else $error("orientation component out of range");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> div_st && launched)
    else $error("divider finished outside a divide step");

  a_sqrt_owner: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> ((state == S_LSQ) || (state == S_NSQ)) && launched)
    else $error("square root finished outside a root step");

  a_press_flag: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !req_type |=> out_valid && !degenerate)
    else $error("press word did not return at once with a clear flag");

endmodule
